// ----- rtl/b64c_pkg.sv -----
// ----------------------------------------------------------------------------
// b64c_pkg
// Types, constants and character tables shared by the Base64 codec modules.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic       MODE_ENC   = 1'b0;
  localparam logic       MODE_DEC   = 1'b1;
  localparam int         QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       error;
  } out_item_t;

  typedef struct packed {
    logic        err;
    logic        enc;
    logic [23:0] bits;
    logic [2:0]  ndata;
    logic [2:0]  total;
    logic        last;
  } job_t;

  typedef struct packed {
    logic       invalid;
    logic [5:0] code;
  } code_t;

  function automatic code_t char_code(input logic [7:0] c);
    code_t r;
    r.invalid = 1'b0;
    r.code    = '0;
    case (c) inside
      [8'h41:8'h5A]: r.code = 6'(c - 8'h41);
      [8'h61:8'h7A]: r.code = 6'(c - 8'h61 + 8'd26);
      [8'h30:8'h39]: r.code = 6'(c - 8'h30 + 8'd52);
      8'h2B:         r.code = 6'd62;
      8'h2F:         r.code = 6'd63;
      default:       r.invalid = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] enc_char(input logic [5:0] idx);
    logic [7:0] r;
    case (idx) inside
      [6'd0:6'd25]:  r = 8'h41 + {2'b00, idx};
      [6'd26:6'd51]: r = 8'h61 + {2'b00, idx} - 8'd26;
      [6'd52:6'd61]: r = 8'h30 + {2'b00, idx} - 8'd52;
      6'd62:         r = 8'h2B;
      default:       r = 8'h2F;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/b64c_front.sv -----
// ----------------------------------------------------------------------------
// b64c_front
// Accepts input beats, gathers groups and classifies each finished group or
// error into a job for the back end.
// ----------------------------------------------------------------------------
module b64c_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_acc,
  input  b64c_pkg::in_item_t in_item,
  input  logic               cfg_we,
  input  logic               cfg_mode,
  output logic               job_push,
  output b64c_pkg::job_t     job
);

  logic        mode_r, mode_nxt;
  logic [23:0] group_r, group_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [2:0]  n;
  logic [23:0] enc_sh;
  logic [23:0] dec_sh;
  logic [1:0]  pad_inc;
  logic        is_pad;
  logic [5:0]  v;
  logic        bad;
  b64c_pkg::code_t cc;

  assign n       = {1'b0, cnt_r} + 3'd1;
  assign enc_sh  = {group_r[15:0], in_item.in_byte};
  assign cc      = b64c_pkg::char_code(in_item.in_byte);
  assign is_pad  = (in_item.in_byte == b64c_pkg::PAD_CHAR);
  assign v       = is_pad ? 6'd0 : cc.code;
  assign dec_sh  = {group_r[17:0], v};
  assign pad_inc = is_pad ? pad_r + 2'd1 : pad_r;
  assign bad     = is_pad ? (cnt_r < 2'd2) : (cc.invalid || (pad_r != 2'd0));

  always_comb begin
    mode_nxt  = mode_r;
    group_nxt = group_r;
    cnt_nxt   = cnt_r;
    pad_nxt   = pad_r;
    job_push  = 1'b0;
    job       = '0;
    job.last  = in_item.in_last;
    if (in_acc) begin
      if (mode_r == b64c_pkg::MODE_ENC) begin
        if ((n < 3'd3) && !in_item.in_last) begin
          group_nxt = enc_sh;
          cnt_nxt   = n[1:0];
        end else begin
          job_push  = 1'b1;
          job.enc   = 1'b1;
          job.ndata = n + 3'd1;
          job.total = 3'd4;
          case (n)
            3'd1:    job.bits = {enc_sh[7:0], 16'h0000};
            3'd2:    job.bits = {enc_sh[15:0], 8'h00};
            default: job.bits = enc_sh;
          endcase
          group_nxt = '0;
          cnt_nxt   = '0;
          pad_nxt   = '0;
        end
      end else begin
        if (bad || ((n < 3'd4) && in_item.in_last) ||
            ((n == 3'd4) && (pad_inc != 2'd0) && !in_item.in_last)) begin
          job_push  = 1'b1;
          job.err   = 1'b1;
          job.total = 3'd1;
          group_nxt = '0;
          cnt_nxt   = '0;
          pad_nxt   = '0;
        end else if (n < 3'd4) begin
          group_nxt = dec_sh;
          cnt_nxt   = n[1:0];
          pad_nxt   = pad_inc;
        end else begin
          job_push  = 1'b1;
          job.bits  = dec_sh;
          job.total = 3'd3 - {1'b0, pad_inc};
          job.ndata = job.total;
          group_nxt = '0;
          cnt_nxt   = '0;
          pad_nxt   = '0;
        end
      end
    end
    if (cfg_we) begin
      mode_nxt  = cfg_mode;
      group_nxt = '0;
      cnt_nxt   = '0;
      pad_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= b64c_pkg::MODE_ENC;
      group_r <= '0;
      cnt_r   <= '0;
      pad_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      group_r <= group_nxt;
      cnt_r   <= cnt_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

// ----- rtl/b64c_queue.sv -----
// ----------------------------------------------------------------------------
// b64c_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module b64c_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64c_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output b64c_pkg::job_t head
);

  b64c_pkg::job_t mem_r [b64c_pkg::QUEUE_DEPTH];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'(b64c_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == 2'd0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? ~wr_r : wr_r;
    rd_nxt  = do_pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/b64c_back.sv -----
// ----------------------------------------------------------------------------
// b64c_back
// Expands each job into its result beats, one per cycle while the output
// register is free or being popped, into the output register.
// ----------------------------------------------------------------------------
module b64c_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  b64c_pkg::job_t      job,
  output logic                job_pop,
  input  logic                out_pop,
  output logic                out_valid,
  output b64c_pkg::out_item_t out_item
);

  logic [1:0]          k_r, k_nxt;
  logic                valid_r, valid_nxt;
  b64c_pkg::out_item_t item_r, item_nxt;
  logic                adv;
  logic                final_beat;
  logic [5:0]          six;
  logic [7:0]          byte_sel;
  b64c_pkg::out_item_t beat;

  assign adv        = job_valid && (!valid_r || out_pop);
  assign final_beat = ({1'b0, k_r} == (job.total - 3'd1));
  assign job_pop    = adv && final_beat;
  assign out_valid  = valid_r;
  assign out_item   = item_r;

  always_comb begin
    case (k_r)
      2'd0:    six = job.bits[23:18];
      2'd1:    six = job.bits[17:12];
      2'd2:    six = job.bits[11:6];
      default: six = job.bits[5:0];
    endcase
    case (k_r)
      2'd0:    byte_sel = job.bits[23:16];
      2'd1:    byte_sel = job.bits[15:8];
      default: byte_sel = job.bits[7:0];
    endcase
    beat.out_last = final_beat && job.last;
    beat.error    = job.err;
    if (job.err) begin
      beat.out_byte = 8'h00;
    end else if (job.enc) begin
      beat.out_byte = ({1'b0, k_r} < job.ndata) ? b64c_pkg::enc_char(six)
                                                : b64c_pkg::PAD_CHAR;
    end else begin
      beat.out_byte = byte_sel;
    end
  end

  always_comb begin
    k_nxt     = k_r;
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (valid_r && out_pop) begin
      valid_nxt = 1'b0;
    end
    if (adv) begin
      valid_nxt = 1'b1;
      item_nxt  = beat;
      k_nxt     = final_beat ? 2'd0 : k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      k_r     <= k_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// ----- rtl/base64_codec.sv -----
// ----------------------------------------------------------------------------
// base64_codec
// Streaming Base64 codec with the standard alphabet, encode or decode.
// ----------------------------------------------------------------------------
// The input side behaves as a queue: a beat is taken when in_push is high
// and in_full is low. Each beat carries one byte (encode) or one character
// (decode) and a flag for the end of the message.
// The result side also behaves as a queue: while out_empty is low the oldest
// result is on out_data, and it is removed when out_pop is high.
// The cfg channel writes the mode (0 encode, 1 decode); cfg_ready is always
// high, and a write clears any partly gathered group.
// A beat that completes a group, or an error, goes as a job through the job
// queue into the output register on its way to out_data. While out_pop is high,
// the back end emits one result per cycle, so decoding and single-beat errors
// take one beat per cycle; encoding is bound by four results per three bytes.
// The two-entry job queue sets how far the input can run ahead of the output.
// After reset the mode is encode, no group is held and out_empty is high.
// If the receiver stops popping, the output register and the job queue fill
// and in_full rises; nothing is lost.
// ----------------------------------------------------------------------------
module base64_codec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  b64c_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output b64c_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  logic           in_acc;
  logic           job_push;
  b64c_pkg::job_t job_in;
  logic           q_full, q_empty;
  b64c_pkg::job_t q_head;
  logic           q_pop;
  logic           out_valid;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign in_acc    = in_push && !q_full;
  assign out_empty = !out_valid;

  b64c_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_item  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_mode (cfg_data),
    .job_push (job_push),
    .job      (job_in)
  );

  b64c_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  b64c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job       (q_head),
    .job_pop   (q_pop),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

// ----- rtl/b64c_checker.sv -----
// ----------------------------------------------------------------------------
// b64c_checker
// Port-level checks on the Base64 codec, bound to the top level.
// ----------------------------------------------------------------------------
module b64c_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_push,
  input logic                in_full,
  input b64c_pkg::in_item_t  in_data,
  input logic                out_empty,
  input logic                out_pop,
  input b64c_pkg::out_item_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic                cfg_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("results present after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.error) |-> (out_data.out_byte == 8'h00))
    else $error("error beat carries a non-zero byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind base64_codec b64c_checker u_chk (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming Base64 codec. It runs directed
// encode and decode cases, then random messages in both modes, with random
// gaps on both sides but in one calm encode run. Each accepted input beat is
// run through a behavioural model in this file; each result is checked in order.
// ----------------------------------------------------------------------------
module tb;
  import b64c_pkg::*;

  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int QUIET_LIMIT = 2000;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_data = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  bit          calm = 1'b0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  logic        codec_mode = MODE_ENC;
  logic [23:0] grp_bits = '0;
  int          grp_cnt = 0;
  int          pad_cnt = 0;
  out_item_t   awaited_out[$];

  base64_codec dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] b64_letter(input logic [5:0] idx);
    return ALPHABET[8 * (63 - int'(idx)) +: 8];
  endfunction

  function automatic int b64_value(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (b64_letter(6'(i)) == c) return i;
    end
    return -1;
  endfunction

  function automatic void clear_group();
    grp_bits = '0;
    grp_cnt  = 0;
    pad_cnt  = 0;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic l, input logic e);
    out_item_t r;
    r.out_byte = b;
    r.out_last = l;
    r.error    = e;
    awaited_out.push_back(r);
  endfunction

  function automatic void fail_group(input logic l);
    clear_group();
    emit(8'h00, l, 1'b1);
  endfunction

  function automatic void base64_predict(input logic [7:0] b, input logic l);
    int          n;
    int          v;
    logic [23:0] bits;
    if (codec_mode == MODE_ENC) begin
      n = grp_cnt + 1;
      grp_bits = {grp_bits[15:0], b};
      if (n < 3 && !l) begin
        grp_cnt = n;
        return;
      end
      bits = grp_bits << (8 * (3 - n));
      for (int k = 0; k < 4; k++) begin
        if (k <= n) begin
          emit(b64_letter(6'(bits >> (18 - 6 * k))), (k == 3) && l, 1'b0);
        end else begin
          emit(PAD_CHAR, (k == 3) && l, 1'b0);
        end
      end
      clear_group();
    end else begin
      if (b == PAD_CHAR) begin
        if (grp_cnt < 2) begin
          fail_group(l);
          return;
        end
        pad_cnt++;
        v = 0;
      end else begin
        v = b64_value(b);
        if (v < 0 || pad_cnt != 0) begin
          fail_group(l);
          return;
        end
      end
      grp_bits = {grp_bits[17:0], 6'(v)};
      n = grp_cnt + 1;
      if (n < 4) begin
        if (l) begin
          fail_group(l);
        end else begin
          grp_cnt = n;
        end
        return;
      end
      if (pad_cnt != 0 && !l) begin
        fail_group(l);
        return;
      end
      for (int k = 0; k < 3 - pad_cnt; k++) begin
        emit(8'(grp_bits >> (16 - 8 * k)), (k == 2 - pad_cnt) && l, 1'b0);
      end
      clear_group();
    end
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic l);
    in_item_t it;
    it.in_byte = b;
    it.in_last = l;
    if (!calm && $urandom_range(99) < 33) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 33);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    base64_predict(b, l);
  endtask

  task automatic send_text(input string s, input logic l);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], l && (i == s.len() - 1));
    end
  endtask

  // The input side stops and every outstanding result is drained before
  // the pipeline is given time to absorb any beat that made no result.
  task automatic settle();
    in_push <= 1'b0;
    while (awaited_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    codec_mode = m;
    clear_group();
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic test_encode_tails();
    set_mode(MODE_ENC);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_text("Man", 1'b1);
  endtask

  task automatic test_decode_cases();
    set_mode(MODE_DEC);
    send_text("+/9z", 1'b1);
    send_text("TR==", 1'b1);
    send_beat(8'hFF, 1'b0);
    send_text("=", 1'b0);
    send_text("TWE=", 1'b0);
    send_text("T", 1'b1);
    send_text("TQ=a", 1'b1);
  endtask

  task automatic test_mode_write_clears();
    set_mode(MODE_ENC);
    send_beat(8'h12, 1'b0);
    send_beat(8'h34, 1'b0);
    set_mode(MODE_ENC);
    send_beat(8'h56, 1'b1);
    set_mode(MODE_DEC);
    send_text("TW", 1'b0);
    set_mode(MODE_DEC);
    send_text("TWFu", 1'b1);
  endtask

  task automatic test_random_encode(input int budget);
    int sent;
    int len;
    sent = 0;
    set_mode(MODE_ENC);
    while (sent < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        send_beat(pick_byte(), i == len - 1);
        sent++;
      end
    end
  endtask

  // Mostly well-formed text with random content; about a quarter of the
  // messages get a stray character, a stray pad or an early end.
  task automatic test_random_decode(input int budget);
    logic [7:0] msg[$];
    int         sent;
    int         pads;
    int         pos;
    sent = 0;
    set_mode(MODE_DEC);
    while (sent < budget) begin
      msg.delete();
      repeat (4 * $urandom_range(3)) msg.push_back(b64_letter(6'($urandom_range(63))));
      pads = $urandom_range(2);
      repeat (4 - pads) msg.push_back(b64_letter(6'($urandom_range(63))));
      repeat (pads) msg.push_back(PAD_CHAR);
      if ($urandom_range(99) < 25) begin
        pos = $urandom_range(msg.size() - 1);
        case ($urandom_range(2))
          0:       msg[pos] = pick_byte();
          1:       msg[pos] = PAD_CHAR;
          default: while (msg.size() > pos + 1) void'(msg.pop_back());
        endcase
      end
      foreach (msg[i]) begin
        send_beat(msg[i], i == msg.size() - 1);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (awaited_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result beat: byte %h last %b error %b",
                   out_data.out_byte, out_data.out_last, out_data.error);
        end
      end else begin
        want = awaited_out.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last ||
            out_data.error !== want.error) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected byte %h last %b error %b, got byte %h last %b error %b",
                     want.out_byte, want.out_last, want.error,
                     out_data.out_byte, out_data.out_last, out_data.error);
          end
        end
      end
    end
    out_pop <= calm || ($urandom_range(99) >= 33);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encode_tails();
    test_decode_cases();
    test_mode_write_clears();
    calm = 1'b1;
    test_random_encode(60);
    calm = 1'b0;
    test_random_decode(70);
    test_random_encode(20);
    test_random_decode(30);
    settle();
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
